// ===== hdl/eti_pkg.sv =====
// Shared types and constants for the escape-time iteration pipeline.
`default_nettype none
package eti_pkg;

  // Width of the point fields as they arrive on the input ports.
  localparam int unsigned InW = 15;
  // Width of the configured limit and of the reported step.
  localparam int unsigned LimitW = 6;
  localparam int unsigned StepW = 6;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(20);

  // Control word that travels alongside each point through the pipeline.
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [StepW-1:0] step;
  } ctl_t;

endpackage
`default_nettype wire

// ===== hdl/eti_mul.sv =====
// Multiply stage: squares and cross product of the current z.
`default_nettype none
module eti_mul #(
  parameter int unsigned NW = 20
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire  eti_pkg::ctl_t          ctl_i,
  input  wire  signed [eti_pkg::InW-1:0] cr_i,
  input  wire  signed [eti_pkg::InW-1:0] ci_i,
  input  wire  signed [NW-1:0]         zr_i,
  input  wire  signed [NW-1:0]         zi_i,
  output eti_pkg::ctl_t                ctl_o,
  output logic signed [eti_pkg::InW-1:0] cr_o,
  output logic signed [eti_pkg::InW-1:0] ci_o,
  output logic signed [2*NW-1:0]       rr_o,
  output logic signed [2*NW-1:0]       ii_o,
  output logic signed [2*NW-1:0]       ri_o
);
  import eti_pkg::*;

  ctl_t                   ctl_q;
  logic signed [InW-1:0]  cr_q, ci_q;
  logic signed [2*NW-1:0] rr_q, ii_q, ri_q;
  logic signed [2*NW-1:0] rr_d, ii_d, ri_d;

  always_comb begin
    rr_d = zr_i * zr_i;
    ii_d = zi_i * zi_i;
    ri_d = zr_i * zi_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cr_q <= cr_i;
      ci_q <= ci_i;
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
    end
  end

  assign ctl_o = ctl_q;
  assign cr_o  = cr_q;
  assign ci_o  = ci_q;
  assign rr_o  = rr_q;
  assign ii_o  = ii_q;
  assign ri_o  = ri_q;

endmodule
`default_nettype wire

// ===== hdl/eti_add.sv =====
// Add stage: escape test of the previous z and the next z = z^2 + c.
`default_nettype none
module eti_add #(
  parameter int unsigned NW            = 20,
  parameter int unsigned FRACTION_BITS = 12,
  parameter int unsigned TEST_STEP     = 0
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            adv_i,
  input  wire  [eti_pkg::LimitW-1:0]     limit_i,
  input  wire  eti_pkg::ctl_t            ctl_i,
  input  wire  signed [eti_pkg::InW-1:0] cr_i,
  input  wire  signed [eti_pkg::InW-1:0] ci_i,
  input  wire  signed [2*NW-1:0]         rr_i,
  input  wire  signed [2*NW-1:0]         ii_i,
  input  wire  signed [2*NW-1:0]         ri_i,
  output eti_pkg::ctl_t                  ctl_o,
  output logic signed [eti_pkg::InW-1:0] cr_o,
  output logic signed [eti_pkg::InW-1:0] ci_o,
  output logic signed [NW-1:0]           zr_o,
  output logic signed [NW-1:0]           zi_o
);
  import eti_pkg::*;

  localparam int unsigned PW = 2 * NW;
  // |z|^2 >= 4 at a scale of 2^(2F).
  localparam logic signed [PW:0] Bound = (PW + 1)'(1) << (2 * FRACTION_BITS + 2);

  ctl_t                  ctl_q, ctl_d;
  logic signed [InW-1:0] cr_q, ci_q;
  logic signed [NW-1:0]  zr_q, zi_q, zr_d, zi_d;
  logic signed [PW:0]    mag, diff, diff_sh;
  logic signed [PW-1:0]  ri_sh;
  logic                  test_en, hit;

  always_comb begin
    mag     = {rr_i[PW-1], rr_i} + {ii_i[PW-1], ii_i};
    hit     = (mag >= Bound);
    // The step before the first is never tested, nor any beyond the limit.
    test_en = (TEST_STEP != 0) && (TEST_STEP <= 32'(limit_i));
    ctl_d   = ctl_i;
    if (ctl_i.valid && !ctl_i.done && test_en && hit) begin
      ctl_d.done = 1'b1;
      ctl_d.step = StepW'(TEST_STEP);
    end
    // Arithmetic shifts give the floor of the scaled products.
    diff    = {rr_i[PW-1], rr_i} - {ii_i[PW-1], ii_i};
    diff_sh = diff >>> FRACTION_BITS;
    ri_sh   = ri_i >>> (FRACTION_BITS - 1);
    zr_d    = diff_sh[NW-1:0] + NW'(cr_i);
    zi_d    = ri_sh[NW-1:0] + NW'(ci_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cr_q <= cr_i;
      ci_q <= ci_i;
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
  end

  assign ctl_o = ctl_q;
  assign cr_o  = cr_q;
  assign ci_o  = ci_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;

endmodule
`default_nettype wire

// ===== hdl/escape_time_iteration_unit.sv =====
// Escape-time iteration unit: unrolled z = z^2 + c pipeline with escape test.
// Pipeline: one multiply stage and one add/test stage for each iteration plus a
// final pair for the last escape test. Throughput: one point per cycle; the whole
// pipeline holds while a finished word waits at the output under stall. Reset
// clears all valid bits and sets the iteration limit to 20.
`default_nettype none
module escape_time_iteration_unit #(
  parameter int unsigned MAX_ITERATIONS = 32,
  parameter int unsigned FRACTION_BITS  = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [eti_pkg::LimitW-1:0]       cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  signed [eti_pkg::InW-1:0]   c_real_i,
  input  wire  signed [eti_pkg::InW-1:0]   c_imag_i,
  input  wire  signed [eti_pkg::InW-1:0]   start_real_i,
  input  wire  signed [eti_pkg::InW-1:0]   start_imag_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             in_set_o,
  output logic [eti_pkg::StepW-1:0]        escape_step_o
);
  import eti_pkg::*;

  // A point that has not escaped stays below 2 in each part.
  localparam int unsigned ZW = (FRACTION_BITS + 2 > InW) ? FRACTION_BITS + 2 : InW;
  localparam int unsigned NW = 2 * ZW - FRACTION_BITS + 2;
  localparam int unsigned NS = MAX_ITERATIONS + 1;

  logic [LimitW-1:0] limit_q;
  logic              adv;

  ctl_t                  a_ctl [NS+1];
  logic signed [InW-1:0] a_cr  [NS+1];
  logic signed [InW-1:0] a_ci  [NS+1];
  logic signed [NW-1:0]  a_zr  [NS+1];
  logic signed [NW-1:0]  a_zi  [NS+1];

  ctl_t                   m_ctl [NS];
  logic signed [InW-1:0]  m_cr  [NS];
  logic signed [InW-1:0]  m_ci  [NS];
  logic signed [2*NW-1:0] m_rr  [NS];
  logic signed [2*NW-1:0] m_ii  [NS];
  logic signed [2*NW-1:0] m_ri  [NS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Every stage moves together; only a waiting word at the output holds them.
  assign adv        = !(a_ctl[NS].valid && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    a_ctl[0]       = '0;
    a_ctl[0].valid = in_valid_i;
    a_cr[0]        = c_real_i;
    a_ci[0]        = c_imag_i;
    a_zr[0]        = NW'(start_real_i);
    a_zi[0]        = NW'(start_imag_i);
  end

  for (genvar k = 1; k <= NS; k++) begin : g_iter
    eti_mul #(
      .NW(NW)
    ) u_mul (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (a_ctl[k-1]),
      .cr_i  (a_cr[k-1]),
      .ci_i  (a_ci[k-1]),
      .zr_i  (a_zr[k-1]),
      .zi_i  (a_zi[k-1]),
      .ctl_o (m_ctl[k-1]),
      .cr_o  (m_cr[k-1]),
      .ci_o  (m_ci[k-1]),
      .rr_o  (m_rr[k-1]),
      .ii_o  (m_ii[k-1]),
      .ri_o  (m_ri[k-1])
    );

    eti_add #(
      .NW           (NW),
      .FRACTION_BITS(FRACTION_BITS),
      .TEST_STEP    (k - 1)
    ) u_add (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .limit_i(limit_q),
      .ctl_i  (m_ctl[k-1]),
      .cr_i   (m_cr[k-1]),
      .ci_i   (m_ci[k-1]),
      .rr_i   (m_rr[k-1]),
      .ii_i   (m_ii[k-1]),
      .ri_i   (m_ri[k-1]),
      .ctl_o  (a_ctl[k]),
      .cr_o   (a_cr[k]),
      .ci_o   (a_ci[k]),
      .zr_o   (a_zr[k]),
      .zi_o   (a_zi[k])
    );
  end

  assign out_valid_o   = a_ctl[NS].valid;
  assign in_set_o      = !a_ctl[NS].done;
  assign escape_step_o = a_ctl[NS].step;

  // A point reported in the set carries no escape step.
  a_inset_no_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_set_o) |-> (escape_step_o == '0))
    else $error("in-set word carries a non-zero escape step");

  // The input is held back only by a word waiting at the output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting output word");

  // A held pipeline keeps the last stage's control word.
  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(a_ctl[NS]))
    else $error("last stage changed while the pipeline was held");

  // The limit changes only through a configuration write.
  a_limit_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(limit_q))
    else $error("iteration limit changed without a write");

endmodule
`default_nettype wire

// ===== dv/escape_time_iteration_checker.sv =====
// Checker for the escape-time unit: predicts each point's escape and compares the results.
module escape_time_iteration_checker #(
  parameter int unsigned MAX_ITERATIONS = 32,
  parameter int unsigned FRACTION_BITS  = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [eti_pkg::LimitW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [eti_pkg::InW-1:0]    c_real_i,
  input  logic signed [eti_pkg::InW-1:0]    c_imag_i,
  input  logic signed [eti_pkg::InW-1:0]    start_real_i,
  input  logic signed [eti_pkg::InW-1:0]    start_imag_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              in_set_i,
  input  logic [eti_pkg::StepW-1:0]         escape_step_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic                      in_set;
    logic [eti_pkg::StepW-1:0] step;
  } escape_result_t;

  escape_result_t              expected_escapes[$];
  logic [eti_pkg::LimitW-1:0]  limit_q = eti_pkg::LimitReset;
  int                          mismatch_count = 0;
  int                          result_index = 0;

  assign fail_count_o = mismatch_count;

  function automatic escape_result_t predict_escape(
    input logic signed [eti_pkg::InW-1:0] cr_f,
    input logic signed [eti_pkg::InW-1:0] ci_f,
    input logic signed [eti_pkg::InW-1:0] zr_f,
    input logic signed [eti_pkg::InW-1:0] zi_f,
    input logic [eti_pkg::LimitW-1:0]     limit
  );
    longint         cr, ci, zr, zi, rr, ii, ri;
    longint         bound;
    int unsigned    runs;
    escape_result_t res;
    cr = cr_f;
    ci = ci_f;
    zr = zr_f;
    zi = zi_f;
    bound = longint'(4) <<< (2 * FRACTION_BITS);
    runs = (limit > MAX_ITERATIONS) ? MAX_ITERATIONS : limit;
    res.in_set = 1'b1;
    res.step = '0;
    // The starting value itself is never tested, only z after each step.
    for (int k = 1; k <= int'(runs); k++) begin
      if (res.in_set) begin
        rr = zr * zr;
        ii = zi * zi;
        ri = zr * zi;
        zr = ((rr - ii) >>> FRACTION_BITS) + cr;
        zi = (ri >>> (FRACTION_BITS - 1)) + ci;
        if (zr * zr + zi * zi >= bound) begin
          res.in_set = 1'b0;
          res.step = eti_pkg::StepW'(k);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH result %0d: %s got %0d, expected %0d", result_index, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    escape_result_t want;
    if (!rst_ni) begin
      limit_q = eti_pkg::LimitReset;
      expected_escapes.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        limit_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_escapes.push_back(predict_escape(c_real_i, c_imag_i, start_real_i,
                                                  start_imag_i, limit_q));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_escapes.size() == 0) begin
          // A word arrived although no point is waiting for its result.
          report_mismatch("queued predictions", 0, 1);
        end else begin
          want = expected_escapes.pop_front();
          if (in_set_i !== want.in_set) begin
            report_mismatch("in_set", int'(in_set_i), int'(want.in_set));
          end
          if (escape_step_i !== want.step) begin
            report_mismatch("escape_step", int'(escape_step_i), int'(want.step));
          end
        end
        result_index++;
      end
      pending_o = expected_escapes.size();
    end
  end

endmodule

// ===== dv/escape_time_iteration_unit_tb.sv =====
// Testbench top for the escape-time unit: stimulus, result sink, watchdog and verdict.
module escape_time_iteration_unit_tb;

  localparam int unsigned MaxIter      = 32;
  localparam int unsigned FracBits     = 12;
  localparam int unsigned Latency      = 2 * (MaxIter + 1);
  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned HoldAtResult = 60;
  localparam int unsigned HoldCycles   = 700;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [eti_pkg::LimitW-1:0]       cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [eti_pkg::InW-1:0]   c_real = '0;
  logic signed [eti_pkg::InW-1:0]   c_imag = '0;
  logic signed [eti_pkg::InW-1:0]   start_real = '0;
  logic signed [eti_pkg::InW-1:0]   start_imag = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             in_set;
  logic [eti_pkg::StepW-1:0]        escape_step;
  int                               fail_count;
  int                               pending;
  bit                               no_idle = 1'b0;
  int unsigned                      idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  escape_time_iteration_unit #(
    .MAX_ITERATIONS(MaxIter),
    .FRACTION_BITS (FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .c_real_i     (c_real),
    .c_imag_i     (c_imag),
    .start_real_i (start_real),
    .start_imag_i (start_imag),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .in_set_o     (in_set),
    .escape_step_o(escape_step)
  );

  escape_time_iteration_checker #(
    .MAX_ITERATIONS(MaxIter),
    .FRACTION_BITS (FracBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .c_real_i     (c_real),
    .c_imag_i     (c_imag),
    .start_real_i (start_real),
    .start_imag_i (start_imag),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .in_set_i     (in_set),
    .escape_step_i(escape_step),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one point; valid stays high on return so that a back-to-back word needs no toggle.
  task automatic send_point(input int cr, input int ci, input int zr, input int zi);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    c_real     <= eti_pkg::InW'(cr);
    c_imag     <= eti_pkg::InW'(ci);
    start_real <= eti_pkg::InW'(zr);
    start_imag <= eti_pkg::InW'(zi);
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic int pick(input int lo, input int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // Mostly points that stay bounded for a while, so that late steps are reached.
  task automatic send_random_point();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      send_point(pick(-8192, 2048), pick(-5000, 5000), 0, 0);
    end else if (kind < 70) begin
      send_point(pick(-4000, 4000), pick(-4000, 4000), pick(-8192, 8192), pick(-8192, 8192));
    end else if (kind < 85) begin
      send_point(pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192));
    end else begin
      send_point(pick(-16384, 16383), pick(-16384, 16383), pick(-16384, 16383),
                 pick(-16384, 16383));
    end
  endtask

  // The limit only changes once every word in flight has come out.
  task automatic write_limit(input int unsigned value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= eti_pkg::LimitW'(value);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned limit, input int count, input bit burst);
    write_limit(limit);
    no_idle = burst;
    repeat (count) send_random_point();
  endtask

  initial begin : point_source
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed points under the reset limit.
    send_point(0, 0, 0, 0);
    send_point(16383, 16383, 16383, 16383);
    send_point(-16384, -16384, -16384, -16384);
    send_point(-16384, 0, 8192, 0);
    send_point(0, 0, 8192, 0);
    send_point(-8192, 0, 0, 0);
    send_point(1024, 0, 0, 0);
    send_point(1025, 0, 0, 0);
    send_point(0, 4096, 0, 0);
    send_point(-4096, 0, 0, 0);
    send_point(0, 0, 4096, 0);
    send_point(0, 0, 4097, 0);
    send_point(0, 8192, 0, 0);
    send_point(8192, 8192, -8192, 8192);
    send_point(-16384, 16383, 16383, -16384);
    send_point(-7000, 0, 0, 0);
    send_point(-1536, 2700, 0, 0);
    // The receiver's long hold-off falls inside this first long phase.
    run_phase(MaxIter, 150, 1'b0);
    run_phase(0, 20, 1'b0);
    run_phase(1, 30, 1'b1);
    run_phase(63, 60, 1'b0);
    run_phase(MaxIter + 1, 30, 1'b1);
    repeat (5) run_phase($urandom_range(0, 63), 40, $urandom_range(0, 3) == 0);
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (Latency + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 11);
      if (taken == HoldAtResult) begin
        hold = HoldCycles;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/eti_pkg.sv
hdl/eti_mul.sv
hdl/eti_add.sv
hdl/escape_time_iteration_unit.sv
dv/escape_time_iteration_checker.sv
dv/escape_time_iteration_unit_tb.sv
